// ===== src/lps_pkg.sv =====
// Shared types and constants for the LiDAR point smoothness block.
// No dependencies; imported by every module in src.
`timescale 1ns / 1ps
package lps_pkg;

   localparam int HALF_WINDOW  = 5;
   localparam int WIN_LEN      = 2 * HALF_WINDOW + 1;
   localparam int WIN_IDX_W    = $clog2(WIN_LEN);
   localparam int COORD_W      = 18;
   localparam int STR_W        = 8;
   localparam int MIN_W        = 17;
   localparam int MAX_W        = 18;
   localparam int CSR_DATA_W   = 18;
   localparam int DIS_W        = 36;
   localparam int ROOT_W       = DIS_W / 2;
   localparam int ROOT_STEPS   = ROOT_W;
   localparam int REM_W        = ROOT_W + 2;
   localparam int ACC_W        = 24;
   localparam int MAG_W        = ACC_W - 1;
   localparam int SQ_W         = 2 * MAG_W;
   localparam int GEO_W        = SQ_W + 2;
   localparam int GEO_HALF_W   = GEO_W / 2;
   localparam int DF_W         = 10;
   localparam int DIV_STEPS    = DF_W;
   localparam int DIV_NUM_W    = 24;
   localparam int DEN_W        = 19;
   localparam int DSH_W        = DEN_W + DIV_STEPS - 1;
   localparam int ACC_CYCLES   = (WIN_LEN > DIV_STEPS + 1) ? WIN_LEN : DIV_STEPS + 1;
   localparam int STEP_W       = 5;
   localparam int IDX_W        = 16;
   localparam int FILL_W       = 4;
   localparam int CURV_W       = 54;
   localparam int RCURV_W      = 32;
   localparam int SCURV_W      = 13;

   localparam logic [DIV_NUM_W-1:0] DEPTH_NUM      = DIV_NUM_W'(512 * 20000);
   localparam logic [DEN_W-1:0]     DEPTH_REF_MM   = DEN_W'(20000);
   localparam logic [DF_W-1:0]      DEPTH_MIN_Q8   = DF_W'(51);
   localparam logic [COORD_W-1:0]   BEHIND_HALF_MM = COORD_W'(500);
   localparam logic [MIN_W-1:0]     MIN_RESET      = MIN_W'(500);
   localparam logic [MAX_W-1:0]     MAX_RESET      = MAX_W'(90000);

   localparam logic CSR_MIN_RANGE = 1'b0;
   localparam logic CSR_MAX_RANGE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQUARE, ST_CHECK, ST_ROOT, ST_PUSH,
      ST_ACCUM, ST_MUL, ST_SCALE, ST_MERGE, ST_EMIT
   } lps_state_type;

   typedef struct packed {
      logic              load;
      logic              square;
      logic              check;
      logic              root_step;
      logic              push;
      logic              acc_step;
      logic              mul;
      logic              scale;
      logic              merge;
      logic              emit;
      logic              finish;
      logic [STEP_W-1:0] step;
   } lps_cmd_type;

   typedef struct packed {
      logic keep;
      logic win_full;
      logic out_free;
   } lps_status_type;

endpackage

// ===== src/lps_ctrl.sv =====
// Sequencer for the smoothness block: one point at a time through the datapath.
// Depends on lps_pkg.
`timescale 1ns / 1ps
module lps_ctrl import lps_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  lps_status_type status,
   output lps_cmd_type    cmd
);

   lps_state_type     state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_CHECK;
         ST_CHECK: begin
            cnt_in   = '0;
            state_in = status.keep ? ST_ROOT : ST_IDLE;
         end
         ST_ROOT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(ROOT_STEPS - 1)) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            cnt_in   = '0;
            state_in = status.win_full ? ST_ACCUM : ST_IDLE;
         end
         ST_ACCUM: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(ACC_CYCLES - 1)) state_in = ST_MUL;
         end
         ST_MUL:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_MERGE;
         ST_MERGE: state_in = ST_EMIT;
         ST_EMIT:  if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.step  = cnt_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SQUARE: cmd.square = 1'b1;
         ST_CHECK: begin
            cmd.check  = 1'b1;
            cmd.finish = !status.keep;
         end
         ST_ROOT: cmd.root_step = 1'b1;
         ST_PUSH: begin
            cmd.push   = 1'b1;
            cmd.finish = !status.win_full;
         end
         ST_ACCUM: cmd.acc_step = 1'b1;
         ST_MUL:   cmd.mul = 1'b1;
         ST_SCALE: cmd.scale = 1'b1;
         ST_MERGE: cmd.merge = 1'b1;
         ST_EMIT: begin
            cmd.emit   = status.out_free;
            cmd.finish = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== src/lps_datapath.sv =====
// Datapath: range gate, bitwise square root, point window, window sums,
// depth-factor divider, scaling multipliers and result register. Depends on lps_pkg.
`timescale 1ns / 1ps
module lps_datapath import lps_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  lps_cmd_type                 cmd,
   output lps_status_type              status,
   input  logic                        csr_write,
   input  logic                        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   input  logic signed [COORD_W-1:0]   req_x_mm,
   input  logic signed [COORD_W-1:0]   req_y_mm,
   input  logic signed [COORD_W-1:0]   req_z_mm,
   input  logic [STR_W-1:0]            req_return_strength,
   input  logic                        req_cloud_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [IDX_W-1:0]            rsp_point_index,
   output logic [ROOT_W-1:0]           rsp_range_mm,
   output logic [CURV_W-1:0]           rsp_curvature,
   output logic [RCURV_W-1:0]          rsp_range_curvature,
   output logic signed [SCURV_W-1:0]   rsp_strength_curvature,
   output logic [DF_W-1:0]             rsp_depth_factor_q8
);

   localparam logic signed [ACC_W-1:0] CENTRE_GAIN = ACC_W'(2 * HALF_WINDOW);
   localparam logic [CURV_W-1:0]  CURV_MAX  = '1;
   localparam logic [RCURV_W-1:0] RCURV_MAX = '1;

   logic [MIN_W-1:0] min_ff;
   logic [MAX_W-1:0] max_ff;

   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic [STR_W-1:0]          s_ff;
   logic                      last_ff;

   logic [DIS_W-1:0] sqx_ff, sqy_ff, sqz_ff, mn_ff, mx_ff;
   logic [DIS_W-1:0] dis;
   logic             behind, keep;

   logic [DIS_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W+1:0]  rem_sh, trial;

   logic signed [COORD_W-1:0] wx_ff [WIN_LEN];
   logic signed [COORD_W-1:0] wy_ff [WIN_LEN];
   logic signed [COORD_W-1:0] wz_ff [WIN_LEN];
   logic [ROOT_W-1:0]         wr_ff [WIN_LEN];
   logic [STR_W-1:0]          ws_ff [WIN_LEN];
   logic [FILL_W-1:0]         fill_ff;
   logic [IDX_W-1:0]          kept_ff;

   logic signed [ACC_W-1:0] ax_ff, ay_ff, az_ff, ar_ff, as_ff;
   logic signed [ACC_W-1:0] ex, ey, ez, er, es, cx, cy, cz, cr, cs;
   logic [WIN_IDX_W-1:0]    widx;
   logic                    in_win, is_centre;

   logic [DSH_W-1:0]     dsh_ff;
   logic [DIV_NUM_W-1:0] drem_ff;
   logic [DF_W-1:0]      q_ff;
   logic [DF_W-1:0]      df;

   logic [MAG_W-1:0]        mx_mag, my_mag, mz_mag, mr_mag;
   logic [SQ_W-1:0]         dx2_ff, dy2_ff, dz2_ff;
   logic [MAG_W+DF_W-1:0]   rc_ff;
   logic [GEO_W-1:0]        geo_ff;
   logic [GEO_HALF_W+DF_W-1:0] plo_ff, phi_ff;
   logic [GEO_W+DF_W-1:0]   curv_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_RESET;
         max_ff <= MAX_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_RANGE: min_ff <= csr_data[MIN_W-1:0];
            CSR_MAX_RANGE: max_ff <= csr_data[MAX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_x_mm;
         y_ff    <= req_y_mm;
         z_ff    <= req_z_mm;
         s_ff    <= req_return_strength;
         last_ff <= req_cloud_last;
      end
      if (cmd.square) begin
         sqx_ff <= DIS_W'(unsigned'(DIS_W'(x_ff) * DIS_W'(x_ff)));
         sqy_ff <= DIS_W'(unsigned'(DIS_W'(y_ff) * DIS_W'(y_ff)));
         sqz_ff <= DIS_W'(unsigned'(DIS_W'(z_ff) * DIS_W'(z_ff)));
         mn_ff  <= DIS_W'(min_ff) * DIS_W'(min_ff);
         mx_ff  <= DIS_W'(max_ff) * DIS_W'(max_ff);
      end
   end

   assign dis    = sqx_ff + sqy_ff + sqz_ff;
   assign behind = x_ff[COORD_W-1] && (y_ff > -$signed(BEHIND_HALF_MM))
                   && (y_ff < $signed(BEHIND_HALF_MM));
   assign keep   = !(dis < mn_ff || dis > mx_ff || behind);

   assign rem_sh = {rem_ff, rad_ff[DIS_W-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         rad_ff  <= dis;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[DIS_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= REM_W'(rem_sh - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= REM_W'(rem_sh);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            wx_ff[i] <= wx_ff[i+1];
            wy_ff[i] <= wy_ff[i+1];
            wz_ff[i] <= wz_ff[i+1];
            wr_ff[i] <= wr_ff[i+1];
            ws_ff[i] <= ws_ff[i+1];
         end
         wx_ff[WIN_LEN-1] <= x_ff;
         wy_ff[WIN_LEN-1] <= y_ff;
         wz_ff[WIN_LEN-1] <= z_ff;
         wr_ff[WIN_LEN-1] <= root_ff;
         ws_ff[WIN_LEN-1] <= s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         kept_ff <= '0;
      end else if (cmd.finish && last_ff) begin
         fill_ff <= '0;
         kept_ff <= '0;
      end else if (cmd.push) begin
         kept_ff <= kept_ff + 1'b1;
         if (fill_ff < FILL_W'(WIN_LEN)) fill_ff <= fill_ff + 1'b1;
      end
   end

   assign widx      = cmd.step[WIN_IDX_W-1:0];
   assign in_win    = cmd.step < STEP_W'(WIN_LEN);
   assign is_centre = cmd.step == STEP_W'(HALF_WINDOW);
   assign ex = ACC_W'(wx_ff[widx]);
   assign ey = ACC_W'(wy_ff[widx]);
   assign ez = ACC_W'(wz_ff[widx]);
   assign er = ACC_W'(signed'({1'b0, wr_ff[widx]}));
   assign es = ACC_W'(signed'({1'b0, ws_ff[widx]}));

   always_comb begin
      cx = '0; cy = '0; cz = '0; cr = '0; cs = '0;
      if (in_win) begin
         if (is_centre) begin
            cx = -(ex * CENTRE_GAIN);
            cy = -(ey * CENTRE_GAIN);
            cz = -(ez * CENTRE_GAIN);
            cr = -(er * CENTRE_GAIN);
            cs = -(es * CENTRE_GAIN);
         end else begin
            cx = ex; cy = ey; cz = ez; cr = er; cs = es;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_step) begin
         if (cmd.step == '0) begin
            ax_ff <= cx; ay_ff <= cy; az_ff <= cz; ar_ff <= cr; as_ff <= cs;
            dsh_ff  <= DSH_W'(DEPTH_REF_MM + DEN_W'(wr_ff[HALF_WINDOW])) << (DIV_STEPS - 1);
            drem_ff <= DEPTH_NUM;
            q_ff    <= '0;
         end else begin
            ax_ff <= ax_ff + cx;
            ay_ff <= ay_ff + cy;
            az_ff <= az_ff + cz;
            ar_ff <= ar_ff + cr;
            as_ff <= as_ff + cs;
            if (cmd.step <= STEP_W'(DIV_STEPS)) begin
               dsh_ff <= dsh_ff >> 1;
               if (DSH_W'(drem_ff) >= dsh_ff) begin
                  drem_ff <= DIV_NUM_W'(DSH_W'(drem_ff) - dsh_ff);
                  q_ff    <= {q_ff[DF_W-2:0], 1'b1};
               end else begin
                  q_ff    <= {q_ff[DF_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   assign df     = (q_ff < DEPTH_MIN_Q8) ? DEPTH_MIN_Q8 : q_ff;
   assign mx_mag = MAG_W'(ax_ff[ACC_W-1] ? -ax_ff : ax_ff);
   assign my_mag = MAG_W'(ay_ff[ACC_W-1] ? -ay_ff : ay_ff);
   assign mz_mag = MAG_W'(az_ff[ACC_W-1] ? -az_ff : az_ff);
   assign mr_mag = MAG_W'(ar_ff[ACC_W-1] ? -ar_ff : ar_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         dx2_ff <= mx_mag * mx_mag;
         dy2_ff <= my_mag * my_mag;
         dz2_ff <= mz_mag * mz_mag;
         rc_ff  <= (MAG_W+DF_W)'(mr_mag) * (MAG_W+DF_W)'(df);
      end
      if (cmd.scale)
         geo_ff <= GEO_W'(dx2_ff) + GEO_W'(dy2_ff) + GEO_W'(dz2_ff);
      if (cmd.merge) begin
         plo_ff <= (GEO_HALF_W+DF_W)'(geo_ff[GEO_HALF_W-1:0]) * (GEO_HALF_W+DF_W)'(df);
         phi_ff <= (GEO_HALF_W+DF_W)'(geo_ff[GEO_W-1:GEO_HALF_W]) * (GEO_HALF_W+DF_W)'(df);
      end
   end

   assign curv_full = ((GEO_W+DF_W)'(phi_ff) << GEO_HALF_W) + (GEO_W+DF_W)'(plo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_point_index        <= kept_ff - IDX_W'(HALF_WINDOW + 1);
         rsp_range_mm           <= wr_ff[HALF_WINDOW];
         rsp_curvature          <= (curv_full > (GEO_W+DF_W)'(CURV_MAX)) ? CURV_MAX
                                   : curv_full[CURV_W-1:0];
         rsp_range_curvature    <= (rc_ff > (MAG_W+DF_W)'(RCURV_MAX)) ? RCURV_MAX
                                   : rc_ff[RCURV_W-1:0];
         rsp_strength_curvature <= as_ff[SCURV_W-1:0];
         rsp_depth_factor_q8    <= df;
      end
   end

   assign status.keep     = keep;
   assign status.win_full = fill_ff >= FILL_W'(WIN_LEN - 1);
   assign status.out_free = !rsp_valid || rsp_ready;

endmodule

// ===== src/lidar_point_smoothness.sv =====
// LiDAR point smoothness: range gate, 11-point window curvature per centre point.
// Usage:
//   Points enter on the req_ channel (valid/ready) one word at a time; a
//   result word leaves on the rsp_ channel for each kept point once eleven
//   kept points fill the window. The result describes the window centre.
//   Points outside the min/max range, or behind the sensor near the axis,
//   give no result. cloud_last empties the window after that point.
//   csr_ is a plain write port: index 0 minimum range, 1 maximum range. The user
//   must write it only while the block is idle; the block does not enforce this.
// Timing:
//   A dropped point passes the square and range-check states; a kept point
//   then runs the bitwise square root and is pushed into the window; a point
//   that gives a result goes on through the window sum, which also carries
//   the 10-step depth divider, the multiply, scale and merge states, and is
//   emitted. One point is handled at a time.
// Reset clears the window fill, the point index and the range registers
// to 500 mm and 90000 mm. A result waits in the output register while the
// receiver stalls; the next point is accepted meanwhile and held before
// its own result until the register frees.
// Depends on lps_pkg, lps_ctrl and lps_datapath.
`timescale 1ns / 1ps
module lidar_point_smoothness import lps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_x_mm,
   input  logic signed [COORD_W-1:0] req_y_mm,
   input  logic signed [COORD_W-1:0] req_z_mm,
   input  logic [STR_W-1:0]          req_return_strength,
   input  logic                      req_cloud_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [IDX_W-1:0]          rsp_point_index,
   output logic [ROOT_W-1:0]         rsp_range_mm,
   output logic [CURV_W-1:0]         rsp_curvature,
   output logic [RCURV_W-1:0]        rsp_range_curvature,
   output logic signed [SCURV_W-1:0] rsp_strength_curvature,
   output logic [DF_W-1:0]           rsp_depth_factor_q8,
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   lps_cmd_type    cmd;
   lps_status_type status;

   lps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lps_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_x_mm               (req_x_mm),
      .req_y_mm               (req_y_mm),
      .req_z_mm               (req_z_mm),
      .req_return_strength    (req_return_strength),
      .req_cloud_last         (req_cloud_last),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_point_index        (rsp_point_index),
      .rsp_range_mm           (rsp_range_mm),
      .rsp_curvature          (rsp_curvature),
      .rsp_range_curvature    (rsp_range_curvature),
      .rsp_strength_curvature (rsp_strength_curvature),
      .rsp_depth_factor_q8    (rsp_depth_factor_q8)
   );

endmodule

// ===== sim/lidar_point_smoothness_tb.sv =====
// Testbench for lidar_point_smoothness: random and directed points against a scoreboard that
// predicts range gating, window curvature and depth factor per centre point.
// Depends on lps_pkg and the RTL in src.
`timescale 1ns / 1ps
module lidar_point_smoothness_tb;
   import lps_pkg::*;

   typedef struct {
      logic [IDX_W-1:0]          index;
      logic [ROOT_W-1:0]         range;
      logic [CURV_W-1:0]         curv;
      logic [RCURV_W-1:0]        rcurv;
      logic signed [SCURV_W-1:0] scurv;
      logic [DF_W-1:0]           df;
   } smooth_word_type;

   class smoothness_board;
      longint unsigned min_mm, max_mm;
      longint wx[WIN_LEN], wy[WIN_LEN], wz[WIN_LEN], wr[WIN_LEN], ws[WIN_LEN];
      int unsigned fill, kept;
      smooth_word_type pending[$];
      int errors;

      function new();
         min_mm = 500;
         max_mm = 90000;
         fill = 0;
         kept = 0;
         errors = 0;
      endfunction

      function void set_range(logic idx, logic [CSR_DATA_W-1:0] d);
         if (idx == CSR_MIN_RANGE) min_mm = 64'(d[MIN_W-1:0]);
         else max_mm = 64'(d[MAX_W-1:0]);
      endfunction

      function longint unsigned root_of(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function longint window_sum(longint w[WIN_LEN]);
         longint acc;
         acc = 0;
         for (int i = 0; i < WIN_LEN; i++) if (i != HALF_WINDOW) acc += w[i];
         return acc - 2 * HALF_WINDOW * w[HALF_WINDOW];
      endfunction

      function longint unsigned absv(longint v);
         return v < 0 ? -v : v;
      endfunction

      function void note_point(logic signed [COORD_W-1:0] x, y, z, logic [STR_W-1:0] s,
                               logic last);
         longint unsigned dis, df, dx, dy, dz, dr, curv, rcurv;
         longint xs, ys, zs;
         smooth_word_type w;
         xs = x;
         ys = y;
         zs = z;
         dis = xs * xs + ys * ys + zs * zs;
         if (!(dis < min_mm * min_mm || dis > max_mm * max_mm || (xs < 0 && absv(ys) < 500)))
         begin
            for (int i = 0; i + 1 < WIN_LEN; i++) begin
               wx[i] = wx[i+1];
               wy[i] = wy[i+1];
               wz[i] = wz[i+1];
               wr[i] = wr[i+1];
               ws[i] = ws[i+1];
            end
            wx[WIN_LEN-1] = xs;
            wy[WIN_LEN-1] = ys;
            wz[WIN_LEN-1] = zs;
            wr[WIN_LEN-1] = root_of(dis);
            ws[WIN_LEN-1] = 64'(s);
            kept = (kept + 1) % 65536;
            if (fill < WIN_LEN) fill++;
            if (fill >= WIN_LEN) begin
               df = 64'd10240000 / (64'd20000 + wr[HALF_WINDOW]);
               if (df < 51) df = 51;
               dx = absv(window_sum(wx));
               dy = absv(window_sum(wy));
               dz = absv(window_sum(wz));
               dr = absv(window_sum(wr));
               curv = (dx * dx + dy * dy + dz * dz) * df;
               if (curv > 64'h3F_FFFF_FFFF_FFFF) curv = 64'h3F_FFFF_FFFF_FFFF;
               rcurv = dr * df;
               if (rcurv > 64'hFFFF_FFFF) rcurv = 64'hFFFF_FFFF;
               w.index = IDX_W'((kept + 2 * 65536 - 1 - HALF_WINDOW) % 65536);
               w.range = ROOT_W'(wr[HALF_WINDOW]);
               w.curv = CURV_W'(curv);
               w.rcurv = RCURV_W'(rcurv);
               w.scurv = SCURV_W'(window_sum(ws));
               w.df = DF_W'(df);
               pending = {pending, w};
            end
         end
         if (last) begin
            fill = 0;
            kept = 0;
         end
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_result(smooth_word_type g);
         smooth_word_type e;
         if (pending.size() == 0) begin
            report("unexpected word index", g.index, 0);
            return;
         end
         e = pending.pop_front();
         if (g.index != e.index) report("point_index", g.index, e.index);
         if (g.range != e.range) report("range_mm", g.range, e.range);
         if (g.curv != e.curv) report("curvature", g.curv, e.curv);
         if (g.rcurv != e.rcurv) report("range_curvature", g.rcurv, e.rcurv);
         if (g.scurv != e.scurv) report("strength_curvature", g.scurv, e.scurv);
         if (g.df != e.df) report("depth_factor_q8", g.df, e.df);
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, req_cloud_last = 0;
   logic signed [COORD_W-1:0] req_x_mm = 0, req_y_mm = 0, req_z_mm = 0;
   logic [STR_W-1:0] req_return_strength = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [IDX_W-1:0] rsp_point_index;
   logic [ROOT_W-1:0] rsp_range_mm;
   logic [CURV_W-1:0] rsp_curvature;
   logic [RCURV_W-1:0] rsp_range_curvature;
   logic signed [SCURV_W-1:0] rsp_strength_curvature;
   logic [DF_W-1:0] rsp_depth_factor_q8;
   logic csr_write = 0, csr_index = CSR_MIN_RANGE;
   logic [CSR_DATA_W-1:0] csr_data = 0;

   smoothness_board board = new();
   bit calm = 0;
   int hold_asks = 0, hold_done = 0, hold_left = 0, quiet = 0;

   lidar_point_smoothness u_dut (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      smooth_word_type g;
      if (!reset && req_valid && req_ready)
         board.note_point(req_x_mm, req_y_mm, req_z_mm, req_return_strength, req_cloud_last);
      if (!reset && rsp_valid && rsp_ready) begin
         g.index = rsp_point_index;
         g.range = rsp_range_mm;
         g.curv = rsp_curvature;
         g.rcurv = rsp_range_curvature;
         g.scurv = rsp_strength_curvature;
         g.df = rsp_depth_factor_q8;
         board.check_result(g);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 0;
         hold_left <= hold_left - 1;
      end else if (hold_done != hold_asks) begin
         hold_done <= hold_asks;
         hold_left <= 400;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 32);
      end
   end

   task write_range(logic idx, logic [CSR_DATA_W-1:0] d);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= d;
      board.set_range(idx, d);
      @(posedge clock);
      csr_write <= 0;
      @(posedge clock);
   endtask

   task send_point(logic signed [COORD_W-1:0] x, y, z, logic [STR_W-1:0] s, logic last);
      req_valid <= 1;
      req_x_mm <= x;
      req_y_mm <= y;
      req_z_mm <= z;
      req_return_strength <= s;
      req_cloud_last <= last;
      do @(posedge clock); while (!req_ready);
      if (!calm && $urandom_range(0, 99) < 32) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task drain;
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] coord(int k);
      logic signed [COORD_W-1:0] v;
      v = COORD_W'($urandom_range(0, (1 << k) - 1));
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   task run_sweeps(int n, int k);
      int left;
      logic signed [COORD_W-1:0] x, y;
      left = 0;
      repeat (n) begin
         if (left == 0) left = $urandom_range(3, 60);
         left--;
         if ($urandom_range(0, 99) < 15) begin
            send_point(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                       STR_W'($urandom), $urandom_range(0, 15) == 0);
         end else begin
            x = coord(k);
            y = coord(k);
            if (x < 0 && y < 500 && y > -500) x = -x;
            send_point(x, y, coord(k), STR_W'($urandom), left == 0);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, drops, behind the sensor, sweep end
      send_point(0, 0, 0, 0, 0);
      send_point(-1000, 100, 0, 9, 0);
      send_point(-1000, -499, 0, 9, 0);
      send_point(131071, 131071, 131071, 255, 0);
      send_point(-131072, -131072, -131072, 255, 0);
      for (int i = 0; i < 14; i++)
         send_point(1000 + 3000 * i, (i % 2) ? -500 : 500, -20 * i, i * 18, 0);
      send_point(89000, 0, 0, 255, 0);
      send_point(60000, -60000, 20000, 0, 0);
      send_point(-70000, 600, 100, 128, 1);
      send_point(600, 0, 0, 1, 1);
      drain();
      write_range(CSR_MIN_RANGE, 18'h3FFFF);
      write_range(CSR_MAX_RANGE, 18'h3FFFF);
      run_sweeps(150, 17);
      drain();
      write_range(CSR_MIN_RANGE, 0);
      write_range(CSR_MAX_RANGE, 18'h3FFFF);
      calm = 1;
      hold_asks++;
      run_sweeps(300, 17);
      calm = 0;
      drain();
      write_range(CSR_MIN_RANGE, 0);
      write_range(CSR_MAX_RANGE, 0);
      run_sweeps(40, 3);
      drain();
      write_range(CSR_MIN_RANGE, 1000);
      write_range(CSR_MAX_RANGE, 50000);
      run_sweeps(400, 15);
      drain();
      write_range(CSR_MIN_RANGE, 500);
      write_range(CSR_MAX_RANGE, 90000);
      hold_asks++;
      run_sweeps(400, 16);
      drain();
      write_range(CSR_MIN_RANGE, 20);
      write_range(CSR_MAX_RANGE, 400);
      run_sweeps(340, 8);
      drain();
      if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== files.f =====
src/lps_pkg.sv
src/lps_ctrl.sv
src/lps_datapath.sv
src/lidar_point_smoothness.sv
sim/lidar_point_smoothness_tb.sv
